[hdl/via_pkg.sv]
package via_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } via_op_t;

    localparam logic [3:0] REG_ORB    = 4'h0;
    localparam logic [3:0] REG_ORA    = 4'h1;
    localparam logic [3:0] REG_DDRB   = 4'h2;
    localparam logic [3:0] REG_DDRA   = 4'h3;
    localparam logic [3:0] REG_T1CL   = 4'h4;
    localparam logic [3:0] REG_T1CH   = 4'h5;
    localparam logic [3:0] REG_T1LL   = 4'h6;
    localparam logic [3:0] REG_T1LH   = 4'h7;
    localparam logic [3:0] REG_T2CL   = 4'h8;
    localparam logic [3:0] REG_T2CH   = 4'h9;
    localparam logic [3:0] REG_SR     = 4'hA;
    localparam logic [3:0] REG_ACR    = 4'hB;
    localparam logic [3:0] REG_PCR    = 4'hC;
    localparam logic [3:0] REG_IFR    = 4'hD;
    localparam logic [3:0] REG_IER    = 4'hE;
    localparam logic [3:0] REG_ORA_NH = 4'hF;

    localparam logic [6:0] FLAG_CA2 = 7'h01;
    localparam logic [6:0] FLAG_CA1 = 7'h02;
    localparam logic [6:0] FLAG_CB2 = 7'h08;
    localparam logic [6:0] FLAG_CB1 = 7'h10;
    localparam logic [6:0] FLAG_T2  = 7'h20;
    localparam logic [6:0] FLAG_T1  = 7'h40;

    localparam int ACR_PB7_OUT   = 7;
    localparam int ACR_T1_FREE   = 6;
    localparam int ACR_T2_PULSE  = 5;
    localparam int PCR_CA1_RISE  = 0;
    localparam int PCR_CB1_RISE  = 4;

    localparam logic [15:0] TIMER_RESET = 16'hFFFF;

endpackage

[hdl/via_timer.sv]
module via_timer
    import via_pkg::*;
(
    input  logic [15:0] count,
    input  logic [7:0]  cycles,
    output logic [15:0] count_next,
    output logic        underflow
);

    logic [16:0] diff;

    assign diff       = {1'b0, count} - {9'b0, cycles};
    assign count_next = diff[15:0];
    // borrow, or landing on all ones
    assign underflow  = diff[16] || (diff[15:0] == TIMER_RESET);

endmodule

[hdl/versatile_interface_adapter.sv]
// Path: from request accept to result valid, a request passes the input register, then the result register.
// Throughput: one request per cycle unless a result waits on m_ready; the result register and input register let a new
// request enter while a finished result waits on m_ready.
// Reset: synchronous, active-low aresetn; ports, direction and control registers clear,
// timer counts and latches go to all ones, PB7 level to one, no flags or enables set.
module versatile_interface_adapter
    import via_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [3:0] s_register_address,
    input  logic [7:0] s_write_data,
    input  logic [7:0] s_tick_cycles,
    input  logic       s_ca1_level,
    input  logic       s_cb1_level,
    input  logic [7:0] s_port_a_pins,
    input  logic [7:0] s_port_b_pins,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_irq_out
);

    // input register
    logic       pipe_valid_reg;
    via_op_t    pipe_op_reg;
    logic [3:0] pipe_addr_reg;
    logic [7:0] pipe_data_reg;
    logic [7:0] pipe_cycles_reg;
    logic       pipe_ca1_reg;
    logic       pipe_cb1_reg;
    logic [7:0] pipe_pa_reg;
    logic [7:0] pipe_pb_reg;

    // result register
    logic       m_valid_reg;
    logic [7:0] m_read_data_reg;
    logic       m_irq_out_reg;

    // block state
    logic [7:0]  pa_out_reg,   pa_out_next;
    logic [7:0]  pb_out_reg,   pb_out_next;
    logic [7:0]  ddra_reg,     ddra_next;
    logic [7:0]  ddrb_reg,     ddrb_next;
    logic [15:0] t1_count_reg, t1_count_next;
    logic [15:0] t1_latch_reg, t1_latch_next;
    logic [15:0] t2_count_reg, t2_count_next;
    logic [7:0]  t2_latch_reg, t2_latch_next;
    logic [7:0]  sr_reg,       sr_next;
    logic [7:0]  acr_reg,      acr_next;
    logic [7:0]  pcr_reg,      pcr_next;
    logic [6:0]  flags_reg,    flags_next;
    logic [6:0]  ier_reg,      ier_next;
    logic        t1_run_reg,   t1_run_next;
    logic        t2_run_reg,   t2_run_next;
    logic        pb7_reg,      pb7_next;
    logic        ca1_last_reg, ca1_last_next;
    logic        cb1_last_reg, cb1_last_next;

    logic        adv;
    logic [7:0]  rd_next;
    logic [7:0]  port_a_in;
    logic [7:0]  port_b_in;
    logic [15:0] t1_dec;
    logic [15:0] t2_dec;
    logic        t1_uf;
    logic        t2_uf;
    logic        irq_now;

    assign adv     = pipe_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !pipe_valid_reg || adv;

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_irq_out   = m_irq_out_reg;

    assign port_a_in = (pa_out_reg & ddra_reg) | (pipe_pa_reg & ~ddra_reg);
    assign port_b_in = (pb_out_reg & ddrb_reg) | (pipe_pb_reg & ~ddrb_reg);
    assign irq_now   = |(flags_reg & ier_reg);

    via_timer u_via_timer1 (
        .count      (t1_count_reg),
        .cycles     (pipe_cycles_reg),
        .count_next (t1_dec),
        .underflow  (t1_uf)
    );

    via_timer u_via_timer2 (
        .count      (t2_count_reg),
        .cycles     (pipe_cycles_reg),
        .count_next (t2_dec),
        .underflow  (t2_uf)
    );

    always_comb begin
        pa_out_next   = pa_out_reg;
        pb_out_next   = pb_out_reg;
        ddra_next     = ddra_reg;
        ddrb_next     = ddrb_reg;
        t1_count_next = t1_count_reg;
        t1_latch_next = t1_latch_reg;
        t2_count_next = t2_count_reg;
        t2_latch_next = t2_latch_reg;
        sr_next       = sr_reg;
        acr_next      = acr_reg;
        pcr_next      = pcr_reg;
        flags_next    = flags_reg;
        ier_next      = ier_reg;
        t1_run_next   = t1_run_reg;
        t2_run_next   = t2_run_reg;
        pb7_next      = pb7_reg;
        ca1_last_next = ca1_last_reg;
        cb1_last_next = cb1_last_reg;
        rd_next       = 8'h00;

        if (adv) begin
            unique case (pipe_op_reg)
                OP_READ: begin
                    unique case (pipe_addr_reg)
                        REG_ORB: begin
                            flags_next = flags_reg & ~(FLAG_CB1 | FLAG_CB2);
                            rd_next    = acr_reg[ACR_PB7_OUT] ? {pb7_reg, port_b_in[6:0]}
                                                              : port_b_in;
                        end
                        REG_ORA: begin
                            flags_next = flags_reg & ~(FLAG_CA1 | FLAG_CA2);
                            rd_next    = port_a_in;
                        end
                        REG_ORA_NH: rd_next = port_a_in;
                        REG_DDRB:   rd_next = ddrb_reg;
                        REG_DDRA:   rd_next = ddra_reg;
                        REG_T1CL: begin
                            flags_next = flags_reg & ~FLAG_T1;
                            rd_next    = t1_count_reg[7:0];
                        end
                        REG_T1CH:   rd_next = t1_count_reg[15:8];
                        REG_T1LL:   rd_next = t1_latch_reg[7:0];
                        REG_T1LH:   rd_next = t1_latch_reg[15:8];
                        REG_T2CL: begin
                            flags_next = flags_reg & ~FLAG_T2;
                            rd_next    = t2_count_reg[7:0];
                        end
                        REG_T2CH:   rd_next = t2_count_reg[15:8];
                        REG_SR:     rd_next = sr_reg;
                        REG_ACR:    rd_next = acr_reg;
                        REG_PCR:    rd_next = pcr_reg;
                        REG_IFR:    rd_next = {irq_now, flags_reg};
                        REG_IER:    rd_next = {1'b1, ier_reg};
                        default:    rd_next = 8'h00;
                    endcase
                end
                OP_WRITE: begin
                    unique case (pipe_addr_reg)
                        REG_ORB: begin
                            pb_out_next = pipe_data_reg;
                            flags_next  = flags_reg & ~(FLAG_CB1 | FLAG_CB2);
                        end
                        REG_ORA: begin
                            pa_out_next = pipe_data_reg;
                            flags_next  = flags_reg & ~(FLAG_CA1 | FLAG_CA2);
                        end
                        REG_ORA_NH: pa_out_next = pipe_data_reg;
                        REG_DDRB:   ddrb_next   = pipe_data_reg;
                        REG_DDRA:   ddra_next   = pipe_data_reg;
                        REG_T1CL, REG_T1LL: t1_latch_next = {t1_latch_reg[15:8], pipe_data_reg};
                        REG_T1CH: begin
                            t1_latch_next = {pipe_data_reg, t1_latch_reg[7:0]};
                            t1_count_next = {pipe_data_reg, t1_latch_reg[7:0]};
                            flags_next    = flags_reg & ~FLAG_T1;
                            t1_run_next   = 1'b1;
                            pb7_next      = 1'b1;
                        end
                        REG_T1LH: begin
                            t1_latch_next = {pipe_data_reg, t1_latch_reg[7:0]};
                            flags_next    = flags_reg & ~FLAG_T1;
                        end
                        REG_T2CL:   t2_latch_next = pipe_data_reg;
                        REG_T2CH: begin
                            t2_count_next = {pipe_data_reg, t2_latch_reg};
                            flags_next    = flags_reg & ~FLAG_T2;
                            t2_run_next   = 1'b1;
                        end
                        REG_SR:     sr_next  = pipe_data_reg;
                        REG_ACR:    acr_next = pipe_data_reg;
                        REG_PCR:    pcr_next = pipe_data_reg;
                        REG_IFR:    flags_next = flags_reg & ~pipe_data_reg[6:0];
                        REG_IER: begin
                            if (pipe_data_reg[7]) begin
                                ier_next = ier_reg | pipe_data_reg[6:0];
                            end else begin
                                ier_next = ier_reg & ~pipe_data_reg[6:0];
                            end
                        end
                        default: ;
                    endcase
                end
                OP_TICK: begin
                    ca1_last_next = pipe_ca1_reg;
                    cb1_last_next = pipe_cb1_reg;
                    if ((pipe_ca1_reg != ca1_last_reg) &&
                        (pcr_reg[PCR_CA1_RISE] == pipe_ca1_reg)) begin
                        flags_next = flags_next | FLAG_CA1;
                    end
                    if ((pipe_cb1_reg != cb1_last_reg) &&
                        (pcr_reg[PCR_CB1_RISE] == pipe_cb1_reg)) begin
                        flags_next = flags_next | FLAG_CB1;
                    end
                    if (t1_run_reg) begin
                        t1_count_next = t1_dec;
                        if (t1_uf) begin
                            flags_next = flags_next | FLAG_T1;
                            pb7_next   = !pb7_reg;
                            if (acr_reg[ACR_T1_FREE]) begin
                                t1_count_next = t1_latch_reg;
                            end else begin
                                t1_run_next = 1'b0;
                            end
                        end
                    end
                    if (t2_run_reg && !acr_reg[ACR_T2_PULSE]) begin
                        t2_count_next = t2_dec;
                        if (t2_uf) begin
                            flags_next  = flags_next | FLAG_T2;
                            t2_run_next = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pipe_op_reg     <= via_op_t'(s_opcode);
            pipe_addr_reg   <= s_register_address;
            pipe_data_reg   <= s_write_data;
            pipe_cycles_reg <= s_tick_cycles;
            pipe_ca1_reg    <= s_ca1_level;
            pipe_cb1_reg    <= s_cb1_level;
            pipe_pa_reg     <= s_port_a_pins;
            pipe_pb_reg     <= s_port_b_pins;
        end
        if (adv) begin
            m_read_data_reg <= rd_next;
            m_irq_out_reg   <= |(flags_next & ier_next);
        end
        if (!aresetn) begin
            pipe_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            pa_out_reg     <= 8'h00;
            pb_out_reg     <= 8'h00;
            ddra_reg       <= 8'h00;
            ddrb_reg       <= 8'h00;
            t1_count_reg   <= TIMER_RESET;
            t1_latch_reg   <= TIMER_RESET;
            t2_count_reg   <= TIMER_RESET;
            t2_latch_reg   <= TIMER_RESET[7:0];
            sr_reg         <= 8'h00;
            acr_reg        <= 8'h00;
            pcr_reg        <= 8'h00;
            flags_reg      <= 7'h00;
            ier_reg        <= 7'h00;
            t1_run_reg     <= 1'b0;
            t2_run_reg     <= 1'b0;
            pb7_reg        <= 1'b1;
            ca1_last_reg   <= 1'b0;
            cb1_last_reg   <= 1'b0;
        end else begin
            pipe_valid_reg <= (s_valid && s_ready) || (pipe_valid_reg && !adv);
            m_valid_reg    <= adv || (m_valid_reg && !m_ready);
            pa_out_reg     <= pa_out_next;
            pb_out_reg     <= pb_out_next;
            ddra_reg       <= ddra_next;
            ddrb_reg       <= ddrb_next;
            t1_count_reg   <= t1_count_next;
            t1_latch_reg   <= t1_latch_next;
            t2_count_reg   <= t2_count_next;
            t2_latch_reg   <= t2_latch_next;
            sr_reg         <= sr_next;
            acr_reg        <= acr_next;
            pcr_reg        <= pcr_next;
            flags_reg      <= flags_next;
            ier_reg        <= ier_next;
            t1_run_reg     <= t1_run_next;
            t2_run_reg     <= t2_run_next;
            pb7_reg        <= pb7_next;
            ca1_last_reg   <= ca1_last_next;
            cb1_last_reg   <= cb1_last_next;
        end
    end

    // irq on the result register tracks the state it was computed from
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_irq_out_reg == irq_now))
        else $error("irq_out does not match flags and enables");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && (pipe_op_reg != OP_READ)) |=> (m_read_data_reg == 8'h00))
        else $error("non-read request returned nonzero data");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && (pipe_op_reg == OP_TICK) && !t1_run_reg) |=> $stable(t1_count_reg))
        else $error("stopped timer 1 changed on tick");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (pipe_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled while pipeline can move");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> $stable(flags_reg) || $past(adv))
        else $error("flags changed without a request");

endmodule
